// ===== src/dtfe_pkg.sv =====
package dtfe_pkg;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int unsigned KEY_W       = 64;
	localparam int unsigned HASH_W      = 64;
	localparam int unsigned CFG_W       = 5;
	localparam int unsigned CAP_RESET   = 16;

	localparam int unsigned IN_TDATA_W  = KEY_W + HASH_W;
	localparam int unsigned OUT_TDATA_W = 8;

	typedef enum logic [1:0] {
		VERDICT_ACCEPTED  = 2'd0,
		VERDICT_DUPLICATE = 2'd1,
		VERDICT_CONFLICT  = 2'd2
	} verdict_t;

endpackage

// ===== src/dtfe_table.sv =====
// Key/hash store with parallel key match and FIFO ring replacement.
// Keys among valid entries are unique (insert only on miss), so match vectors are OR-reduced.
module dtfe_table #(
	parameter int unsigned DEPTH = dtfe_pkg::TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd_en,
	input  logic [dtfe_pkg::KEY_W-1:0]    key,
	input  logic [dtfe_pkg::HASH_W-1:0]   hash,
	input  logic [dtfe_pkg::CFG_W-1:0]    cap_cfg,
	output dtfe_pkg::verdict_t            verdict
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > dtfe_pkg::CFG_W) ? CNT_W : dtfe_pkg::CFG_W;

	logic [dtfe_pkg::KEY_W-1:0]  key_q  [DEPTH];
	logic [dtfe_pkg::HASH_W-1:0] hash_q [DEPTH];
	logic [DEPTH-1:0]            valid_q;
	logic [IDX_W-1:0]            oldest_q;
	logic [CNT_W-1:0]            count_q;

	logic [DEPTH-1:0] hit_vec;
	logic [DEPTH-1:0] dup_vec;
	logic             hit;
	logic             dup;
	logic [CMP_W-1:0] cfg_ext;
	logic [CMP_W-1:0] cap;
	logic             evict;
	logic [CNT_W:0]   slot_sum;
	logic [CNT_W:0]   slot_wrap;
	logic [IDX_W-1:0] ins_slot;
	logic [IDX_W-1:0] oldest_next;
	logic [DEPTH-1:0] valid_next;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key);
			dup_vec[i] = hit_vec[i] && (hash_q[i] == hash);
		end
	end

	assign hit = |hit_vec;
	assign dup = |dup_vec;

	always_comb begin
		if (hit) begin
			verdict = dup ? dtfe_pkg::VERDICT_DUPLICATE : dtfe_pkg::VERDICT_CONFLICT;
		end else begin
			verdict = dtfe_pkg::VERDICT_ACCEPTED;
		end
	end

	// capacity saturated to 1..DEPTH
	assign cfg_ext = CMP_W'(cap_cfg);
	always_comb begin
		if (cfg_ext == '0) begin
			cap = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(DEPTH)) begin
			cap = CMP_W'(DEPTH);
		end else begin
			cap = cfg_ext;
		end
	end

	assign evict = CMP_W'(count_q) >= cap;

	// insert slot is oldest + count either way (evict shifts both by one)
	assign slot_sum  = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
	assign slot_wrap = (slot_sum >= (CNT_W + 1)'(DEPTH)) ? slot_sum - (CNT_W + 1)'(DEPTH)
	                                                    : slot_sum;
	assign ins_slot  = slot_wrap[IDX_W-1:0];

	assign oldest_next = (oldest_q == IDX_W'(DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);

	// full ring: insert slot equals the evicted slot, the set wins
	always_comb begin
		valid_next = valid_q;
		if (evict) begin
			valid_next[oldest_q] = 1'b0;
		end
		valid_next[ins_slot] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			oldest_q <= '0;
			count_q  <= '0;
		end else if (upd_en && !hit) begin
			valid_q <= valid_next;
			if (evict) begin
				oldest_q <= oldest_next;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en && !hit) begin
			key_q[ins_slot]  <= key;
			hash_q[ins_slot] <= hash;
		end
	end

endmodule

// ===== src/dedup_table_fifo_eviction_top.sv =====
// Duplicate-detection table, FIFO replacement.
// Registers: input register, then result register; a stalled result stream holds both.
// Throughput: one item per cycle while the result stream is not stalled; the key match
// against all entries and the ring update are one combinational pass between the input
// and result registers.
// Reset: table empty, ring pointers zero, capacity 16; no clearing pass needed.
module dedup_table_fifo_eviction_top #(
	parameter int unsigned TABLE_DEPTH = dtfe_pkg::TABLE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// config: entries_in_use
	input  logic                                 cfg_we,
	input  logic [dtfe_pkg::CFG_W-1:0]           cfg_wdata,

	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [dtfe_pkg::IN_TDATA_W-1:0]      s_tdata,   // [63:0] key, [127:64] hash

	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dtfe_pkg::OUT_TDATA_W-1:0]     m_tdata    // [1:0] verdict, [7:2] zero
);

	logic                           s1_valid_q;
	logic [dtfe_pkg::KEY_W-1:0]     key_s1;
	logic [dtfe_pkg::HASH_W-1:0]    hash_s1;

	logic                           res_valid_q;
	dtfe_pkg::verdict_t             verdict_q;

	logic [dtfe_pkg::CFG_W-1:0]     cap_q;

	dtfe_pkg::verdict_t             verdict_c;
	logic                           advance;

	// stage 1 moves into the result register when that one is free or drained
	assign advance  = s1_valid_q && (!res_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= dtfe_pkg::CFG_W'(dtfe_pkg::CAP_RESET);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1  <= s_tdata[dtfe_pkg::KEY_W-1:0];
			hash_s1 <= s_tdata[dtfe_pkg::IN_TDATA_W-1:dtfe_pkg::KEY_W];
		end
		if (advance) begin
			verdict_q <= verdict_c;
		end
	end

	// table lookup and update; table state changes on the same edge the verdict is captured
	dtfe_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd_en  (advance),
		.key     (key_s1),
		.hash    (hash_s1),
		.cap_cfg (cap_q),
		.verdict (verdict_c)
	);

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {(dtfe_pkg::OUT_TDATA_W - 2)'(0), verdict_q};

endmodule

// ===== sim/dedup_table_fifo_eviction_top_test.sv =====
`timescale 1ns / 100ps

// Checks the duplicate-detection table against its own model of the table.
// Items go in on the slave stream and one verdict comes out per item on the master stream.
// The model table is updated at every input transfer; each verdict transfer is checked
// against the oldest pending verdict.
module dedup_table_fifo_eviction_top_test;

	localparam int unsigned DEPTH         = dtfe_pkg::TABLE_DEPTH;
	localparam int unsigned KEY_W         = dtfe_pkg::KEY_W;
	localparam int unsigned HASH_W        = dtfe_pkg::HASH_W;
	localparam int unsigned CFG_W         = dtfe_pkg::CFG_W;
	localparam int unsigned SETTLE_CYCLES = 4;     // margin after the last verdict is back
	localparam int unsigned WATCHDOG_MAX  = 2000;  // cycles with no transfer at all
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned KEY_POOL      = 24;    // more keys than slots, so entries get evicted
	localparam int unsigned STALL_CYCLES  = 300;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_we;
	logic [CFG_W-1:0]                     cfg_wdata;
	logic                                 s_tvalid;
	logic                                 s_tready;
	logic [dtfe_pkg::IN_TDATA_W-1:0]      s_tdata;    // [63:0] key, [127:64] hash
	logic                                 m_tvalid;
	logic                                 m_tready;
	logic [dtfe_pkg::OUT_TDATA_W-1:0]     m_tdata;    // [1:0] verdict, [7:2] zero

	// model of the table
	logic [KEY_W-1:0]  model_keys   [DEPTH];
	logic [HASH_W-1:0] model_hashes [DEPTH];
	logic              model_valid  [DEPTH];
	int unsigned       model_oldest;
	int unsigned       model_count;
	logic [CFG_W-1:0]  model_capacity;

	dtfe_pkg::verdict_t pending_verdicts[$];

	// traffic shaping, set by the tests
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned stall_request;    // picked up by the receiver process
	int unsigned stall_left;

	// random key pool, two payload hashes per key so hits split into duplicates and conflicts
	logic [KEY_W-1:0]  pool_keys   [KEY_POOL];
	logic [HASH_W-1:0] pool_hashes [KEY_POOL][2];

	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	dedup_table_fifo_eviction_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Lookup, FIFO eviction and insert for one packet; returns the verdict it earns.
	function automatic dtfe_pkg::verdict_t classify_packet(input logic [KEY_W-1:0] key,
			input logic [HASH_W-1:0] hash);
		int unsigned cap;
		int unsigned slot;
		for (int i = 0; i < DEPTH; i++) begin
			if (model_valid[i] && model_keys[i] == key) begin
				if (model_hashes[i] == hash)
					return dtfe_pkg::VERDICT_DUPLICATE;
				return dtfe_pkg::VERDICT_CONFLICT;
			end
		end
		// capacity saturates to 1..DEPTH
		cap = model_capacity;
		if (cap < 1)
			cap = 1;
		if (cap > DEPTH)
			cap = DEPTH;
		// miss: drop the oldest entry when full; the fill level never shrinks otherwise
		if (model_count >= cap && model_count > 0) begin
			slot = model_oldest;
			model_valid[slot]  = 1'b0;
			model_keys[slot]   = '0;
			model_hashes[slot] = '0;
			model_oldest = (slot + 1) % DEPTH;
			model_count--;
		end
		if (model_count < DEPTH) begin
			slot = (model_oldest + model_count) % DEPTH;
			model_keys[slot]   = key;
			model_hashes[slot] = hash;
			model_valid[slot]  = 1'b1;
			model_count++;
		end
		return dtfe_pkg::VERDICT_ACCEPTED;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Monitor: tracks config writes and input transfers in the model, checks every verdict
	// transfer, and runs the watchdog. Input side first, so a same-edge push precedes a pop.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				model_capacity = cfg_wdata;
			if (s_tvalid && s_tready) begin
				dtfe_pkg::verdict_t fresh;
				fresh = classify_packet(s_tdata[KEY_W-1:0], s_tdata[KEY_W +: HASH_W]);
				pending_verdicts.insert(pending_verdicts.size(), fresh);
			end
			if (m_tvalid && m_tready) begin
				if (pending_verdicts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected verdict transfer: tdata 0x%02h", m_tdata);
				end else begin
					dtfe_pkg::verdict_t want;
					want = pending_verdicts[0];
					pending_verdicts.delete(0);
					if (m_tdata !== {6'b0, want}) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("verdict mismatch: expected %s (0x%02h) got 0x%02h",
								want.name(), {6'b0, want}, m_tdata);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("watchdog: no transfer for %0d cycles, %0d verdicts pending",
					quiet_cycles, pending_verdicts.size());
				$display("dedup_table_fifo_eviction_top_test: FAIL");
				$finish;
			end
		end
	end

	// Receiver: random idling, plus a long hold-off when a test asks for one.
	always @(posedge clk) begin
		if (stall_request > 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// One input transfer; valid stays high into the next call unless that call idles.
	task automatic send_packet(input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {hash, key};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait until every verdict is back, then let the pipeline settle.
	task automatic drain_verdicts();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] value);
		drain_verdicts();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// All three verdicts with all-zero, all-one and alternating keys and hashes.
	// Runs at the reset capacity.
	task automatic test_verdict_codes();
		send_packet('0, '0);                          // accepted
		send_packet('1, '1);                          // accepted
		send_packet('0, '0);                          // duplicate
		send_packet('0, '1);                          // conflict
		send_packet('1, '0);                          // conflict
		send_packet({32{2'b01}}, {32{2'b10}});        // accepted
		send_packet('1, '1);                          // duplicate
	endtask

	// Capacity dropped below the fill level: the table keeps its entries and every miss
	// evicts the oldest one. Zero behaves as one.
	task automatic test_capacity_eviction();
		write_capacity(5'd1);
		send_packet(64'd1, 64'd1);                    // evicts key zero
		send_packet('0, '0);                          // gone, so accepted again
		send_packet('1, '1);                          // gone, so accepted again
		send_packet(64'd1, 64'd1);                    // still stored
		write_capacity(5'd0);
		send_packet({32{2'b10}}, {32{2'b01}});
		send_packet(64'd1, 64'd2);
		send_packet({32{2'b10}}, {32{2'b01}});
	endtask

	task automatic send_random_packet();
		int unsigned pick;
		int unsigned roll;
		pick = $urandom_range(KEY_POOL - 1);
		roll = $urandom_range(99);
		if (roll < 15)
			send_packet(rand64(), rand64());          // full-width noise
		else if (roll < 25)
			send_packet(pool_keys[pick], rand64());   // known key, fresh payload
		else
			send_packet(pool_keys[pick], pool_hashes[pick][$urandom_range(1)]);
	endtask

	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
			input logic [CFG_W-1:0] capacity, input int unsigned packets);
		write_capacity(capacity);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (packets) send_random_packet();
	endtask

	// Receiver holds off while the sender keeps pushing, so the table stalls its input;
	// then the sender pauses until everything is back.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = STALL_CYCLES;
		repeat (60) send_random_packet();
		drain_verdicts();
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		stall_request  = 0;
		stall_left     = 0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		for (int i = 0; i < DEPTH; i++) begin
			model_keys[i]   = '0;
			model_hashes[i] = '0;
			model_valid[i]  = 1'b0;
		end
		model_oldest   = 0;
		model_count    = 0;
		model_capacity = CFG_W'(dtfe_pkg::CAP_RESET);
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_keys[i]      = rand64();
			pool_hashes[i][0] = rand64();
			pool_hashes[i][1] = rand64();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_verdict_codes();
		test_capacity_eviction();
		// small ring, then an oversized setting that must saturate at the table depth, then full depth
		test_random_traffic(35, 58, 5'd6, 190);
		test_random_traffic(58, 35, 5'd31, 190);
		test_random_traffic(0, 0, 5'd16, 190);
		test_backpressure();

		drain_verdicts();
		if (pending_verdicts.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("dedup_table_fifo_eviction_top_test: PASS");
		else
			$display("dedup_table_fifo_eviction_top_test: FAIL");
		$finish;
	end

endmodule

// ===== dedup_table_fifo_eviction_top.f =====
src/dtfe_pkg.sv
src/dtfe_table.sv
src/dedup_table_fifo_eviction_top.sv
sim/dedup_table_fifo_eviction_top_test.sv
